// ===== rtl/nibble_dictionary_packer_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef NIBBLE_DICTIONARY_PACKER_CORE_DEFINES_SVH
`define NIBBLE_DICTIONARY_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, ignored in reset.
`define NDP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, ignored in reset.
`define NDP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ndp_pkg.sv =====
package ndp_pkg;

    localparam int DICT_ENTRIES_DEF = 15;
    localparam int NIB_W            = 4;
    localparam int BYTE_W           = 8;
    localparam int FUNC_W           = 3;

    localparam logic [FUNC_W-1:0] FN_LEARN  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DUMP   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ENCODE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FLUSH  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

    localparam logic KIND_DICT = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              clear;
        logic              rotate;
        logic              learn;
        logic [NIB_W-1:0]  count;
        logic [BYTE_W-1:0] key;
    } t_cell_ctl;

endpackage

// ===== rtl/ndp_cell.sv =====
module ndp_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ndp_pkg::t_cell_ctl        i_ctl,
    input  logic [ndp_pkg::BYTE_W-1:0] i_nb_data,
    input  logic                      i_nb_valid,
    input  logic                      i_hit_acc,
    input  logic [ndp_pkg::NIB_W-1:0]  i_idx_acc,
    output logic [ndp_pkg::BYTE_W-1:0] o_data,
    output logic                      o_valid,
    output logic                      o_hit_acc,
    output logic [ndp_pkg::NIB_W-1:0]  o_idx_acc
);
    import ndp_pkg::*;

    localparam logic [NIB_W-1:0] CELL_IDX = NIB_W'(IDX);

    logic [BYTE_W-1:0] r_data;
    logic              r_valid;
    logic              w_hit;

    // Entries are unique, so at most one cell hits: OR the index along the row.
    assign w_hit     = r_valid && (r_data == i_ctl.key);
    assign o_hit_acc = i_hit_acc | w_hit;
    assign o_idx_acc = i_idx_acc | (w_hit ? CELL_IDX : '0);
    assign o_data    = r_data;
    assign o_valid   = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_data  <= '0;
            r_valid <= 1'b0;
        end else if (i_ctl.rotate) begin
            r_data  <= i_nb_data;
            r_valid <= i_nb_valid;
        end else if (i_ctl.learn && (i_ctl.count == CELL_IDX)) begin
            r_data  <= i_ctl.key;
            r_valid <= 1'b1;
        end
    end

endmodule

// ===== rtl/nibble_dictionary_packer_core.sv =====
// A result word is registered and shown the cycle after its item is accepted; the first
// word of a dump is registered once the sequencer is in its dump state and the output is free.
// Learn, encode, flush and clear items are taken with no busy state, whenever the output is free.
// Dump: the row of cells rotates once per word loaded, DICT_ENTRIES words in all, and the input
// is held off until the last dump word is loaded; each dump word waits on the output.
// Reset (synchronous, active low) empties every cell, the count and the held nibble.
module nibble_dictionary_packer_core #(
    parameter int DICT_ENTRIES = ndp_pkg::DICT_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ndp_pkg::FUNC_W-1:0]  i_func,
    input  logic [ndp_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ndp_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_out_kind,
    output logic                        o_last_of_run,
    output logic                        o_error_flag
);
    import ndp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    localparam logic [NIB_W-1:0] FULL_CNT = NIB_W'(DICT_ENTRIES);
    localparam logic [NIB_W-1:0] LAST_CNT = NIB_W'(DICT_ENTRIES - 1);

    // Sequencer state
    logic              r_state,   n_state;
    logic [NIB_W-1:0]  r_count,   n_count;
    logic [NIB_W-1:0]  r_dcnt,    n_dcnt;
    logic              r_pending, n_pending;
    logic [NIB_W-1:0]  r_held,    n_held;
    logic              r_herr,    n_herr;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte,  n_out_byte;
    logic              r_out_kind,  n_out_kind;
    logic              r_out_last,  n_out_last;
    logic              r_out_err,   n_out_err;

    t_cell_ctl         w_ctl;
    logic              w_out_free;
    logic              w_accept;
    logic [NIB_W-1:0]  w_nib;

    // Cell row: data and valid rotate towards cell 0, lookup ORs along the row
    logic [BYTE_W-1:0] w_cdata  [DICT_ENTRIES];
    logic              w_cvalid [DICT_ENTRIES];
    logic              w_hit    [DICT_ENTRIES+1];
    logic [NIB_W-1:0]  w_idx    [DICT_ENTRIES+1];

    assign w_hit[0] = 1'b0;
    assign w_idx[0] = '0;

    for (genvar g = 0; g < DICT_ENTRIES; g++) begin : g_cell
        ndp_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_nb_data  (w_cdata[(g + 1) % DICT_ENTRIES]),
            .i_nb_valid (w_cvalid[(g + 1) % DICT_ENTRIES]),
            .i_hit_acc  (w_hit[g]),
            .i_idx_acc  (w_idx[g]),
            .o_data     (w_cdata[g]),
            .o_valid    (w_cvalid[g]),
            .o_hit_acc  (w_hit[g+1]),
            .o_idx_acc  (w_idx[g+1])
        );
    end

    // Output is free when empty or when its word is taken this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // Unknown byte encodes as index zero
    assign w_nib = w_hit[DICT_ENTRIES] ? w_idx[DICT_ENTRIES] : '0;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dcnt      = r_dcnt;
        n_pending   = r_pending;
        n_held      = r_held;
        n_herr      = r_herr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;

        w_ctl        = '0;
        w_ctl.count  = r_count;
        w_ctl.key    = i_data_byte;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_func)
                        FN_LEARN: begin
                            // Known byte: nothing to do. Full: report the byte back.
                            if (!w_hit[DICT_ENTRIES]) begin
                                if (r_count == FULL_CNT) begin
                                    n_out_valid = 1'b1;
                                    n_out_byte  = i_data_byte;
                                    n_out_kind  = KIND_DICT;
                                    n_out_last  = 1'b1;
                                    n_out_err   = 1'b1;
                                end else begin
                                    w_ctl.learn = 1'b1;
                                    n_count     = r_count + 1'b1;
                                end
                            end
                        end
                        FN_DUMP: begin
                            n_state = ST_DUMP;
                            n_dcnt  = '0;
                        end
                        FN_ENCODE: begin
                            if (!r_pending) begin
                                n_pending = 1'b1;
                                n_held    = w_nib;
                                n_herr    = !w_hit[DICT_ENTRIES];
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_byte  = {r_held, w_nib};
                                n_out_kind  = KIND_DATA;
                                n_out_last  = 1'b1;
                                n_out_err   = r_herr || !w_hit[DICT_ENTRIES];
                                n_pending   = 1'b0;
                                n_held      = '0;
                                n_herr      = 1'b0;
                            end
                        end
                        FN_FLUSH: begin
                            // Pad the held nibble with a copy of itself
                            if (r_pending) begin
                                n_out_valid = 1'b1;
                                n_out_byte  = {r_held, r_held};
                                n_out_kind  = KIND_DATA;
                                n_out_last  = 1'b1;
                                n_out_err   = r_herr;
                                n_pending   = 1'b0;
                                n_held      = '0;
                                n_herr      = 1'b0;
                            end
                        end
                        FN_CLEAR: begin
                            w_ctl.clear = 1'b1;
                            n_count     = '0;
                            n_pending   = 1'b0;
                            n_held      = '0;
                            n_herr      = 1'b0;
                        end
                        default: begin
                            // Undefined function codes: drop the word
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                // Emit cell 0 and rotate; after a full turn the row is back in place
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = w_cvalid[0] ? w_cdata[0] : '0;
                    n_out_kind   = KIND_DICT;
                    n_out_last   = (r_dcnt == LAST_CNT);
                    n_out_err    = 1'b0;
                    w_ctl.rotate = 1'b1;
                    n_dcnt       = r_dcnt + 1'b1;
                    if (r_dcnt == LAST_CNT) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dcnt      <= '0;
            r_pending   <= 1'b0;
            r_held      <= '0;
            r_herr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dcnt      <= n_dcnt;
            r_pending   <= n_pending;
            r_held      <= n_held;
            r_herr      <= n_herr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: hold until replaced by the next word
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_kind    = r_out_kind;
    assign o_last_of_run = r_out_last;
    assign o_error_flag  = r_out_err;

endmodule

// ===== rtl/ndp_checker.sv =====
`include "nibble_dictionary_packer_core_defines.svh"

module ndp_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic [ndp_pkg::FUNC_W-1:0]  i_func,
    input  logic [ndp_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [ndp_pkg::BYTE_W-1:0]  o_out_byte,
    input  logic                        o_out_kind,
    input  logic                        o_last_of_run,
    input  logic                        o_error_flag
);
    import ndp_pkg::*;

    // Waiting input word stays offered and unchanged
    `NDP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_func) && $stable(i_data_byte), "input word changed while waiting")

    // Stalled word holds its byte and last flag
    `NDP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_last_of_run), "output word changed while stalled")

    // A packed byte is always the single word of its item
    `NDP_ASSERT_IMP(a_data_last, i_clk, i_rst_n, o_out_valid && (o_out_kind == KIND_DATA), o_last_of_run, "packed byte without last flag")

    // A dictionary word with an error is the full-dictionary report, never part of a dump
    `NDP_ASSERT_IMP(a_dict_err_last, i_clk, i_rst_n, o_out_valid && (o_out_kind == KIND_DICT) && o_error_flag, o_last_of_run, "error inside dump run")

    // No item is taken while a dump run is still going out
    `NDP_ASSERT_IMP(a_dump_busy, i_clk, i_rst_n, o_out_valid && !o_last_of_run, !o_in_ready, "input taken mid dump")

endmodule

bind nibble_dictionary_packer_core ndp_checker u_ndp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_func        (i_func),
    .i_data_byte   (i_data_byte),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_out_kind    (o_out_kind),
    .o_last_of_run (o_last_of_run),
    .o_error_flag  (o_error_flag)
);
